### hdl/lbfs_pkg.sv
// Package for the linked-block file store: sizes, codes and the structs
// that pass between the front end, the command engine and the result queue.
// Depends on nothing.
`default_nettype none
package lbfs_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int MAX_ENTRIES = 32;
  localparam int KEY_BITS    = 32;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] LINK_END = 7'h7F;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOMEM    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_TOOLONG  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  // Classified input beat.
  typedef enum logic [2:0] {
    K_STAGE,
    K_CREATE,
    K_UPDATE,
    K_READ,
    K_DELETE
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE_CHK,
    S_ALLOC,
    S_ALLOC_END,
    S_TBL_WR,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_UPD_RD,
    S_UPD_WR,
    S_RD_RD,
    S_RD_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_RESP
  } fsm_e;

  typedef struct packed {
    kind_e               kind;
    logic [KEY_BITS-1:0] key;
    logic [7:0]          ch;
    logic                ch_valid;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] start;
    logic [6:0] len;
    logic [5:0] idx;
    logic [7:0] ch;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [BLK_W-1:0]    start;
    logic [CNT_W-1:0]    len;
  } entry_t;

endpackage
`default_nettype wire

### hdl/lbfs_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry command queue for the engine. Depends on lbfs_pkg.
`default_nettype none
module lbfs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [1:0]    operation_i,
  input  wire logic [31:0]   file_key_i,
  input  wire logic [7:0]    data_char_i,
  input  wire logic          char_valid_i,
  input  wire logic          last_char_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_take_i,
  output lbfs_pkg::cmd_t     cmd_o
);
  import lbfs_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       wr_en, rd_en;

  // Decide what the beat asks of the engine.
  always_comb begin
    cmd_in.key      = file_key_i[KEY_BITS-1:0];
    cmd_in.ch       = data_char_i;
    cmd_in.ch_valid = char_valid_i;
    case (op_e'(operation_i))
      OP_READ:   cmd_in.kind = K_READ;
      OP_DELETE: cmd_in.kind = K_DELETE;
      OP_CREATE: cmd_in.kind = last_char_i ? K_CREATE : K_STAGE;
      OP_UPDATE: cmd_in.kind = last_char_i ? K_UPDATE : K_STAGE;
      default:   cmd_in.kind = K_STAGE;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

### hdl/lbfs_rq.sv
// Four-entry result queue between the engine and the result ports.
// Depends on lbfs_pkg.
`default_nettype none
module lbfs_rq (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  lbfs_pkg::res_t res_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output lbfs_pkg::res_t res_o
);
  import lbfs_pkg::*;

  res_t       q_mem [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign res_o   = q_mem[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  // Fill count follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule
`default_nettype wire

### hdl/lbfs_back.sv
// Command engine: staging buffer, block store, file table and the
// sequencer that walks chains and the table. Depends on lbfs_pkg.
`default_nettype none
module lbfs_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  lbfs_pkg::cmd_t cmd_i,
  output logic           cmd_take_o,
  input  wire logic      rq_full_i,
  output logic           rq_push_o,
  output lbfs_pkg::res_t rq_res_o
);
  import lbfs_pkg::*;

  // Memories.
  logic [7:0]        stg_mem  [NUM_BLOCKS];
  logic [7:0]        data_mem [NUM_BLOCKS];
  logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
  entry_t            ent_mem  [MAX_ENTRIES];

  fsm_e                state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    stg_cnt_q, stg_cnt_d;
  logic                stg_ovf_q, stg_ovf_d;
  logic [CNT_W-1:0]    free_cnt_q, free_cnt_d;
  logic [ECNT_W-1:0]   ent_cnt_q, ent_cnt_d;
  logic [ECNT_W-1:0]   idx_q, idx_d;
  logic [LINK_W-1:0]   b_q, b_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [BLK_W-1:0]    prev_q, prev_d, first_q, first_d, scan_q, scan_d;
  logic [BLK_W-1:0]    start_q, start_d;
  logic [CNT_W-1:0]    len_q, len_d;
  status_e             status_q, status_d;
  logic [NUM_BLOCKS-1:0] taken_q, taken_d;

  logic [7:0]        stg_rdata, data_rdata;
  logic [LINK_W-1:0] link_rdata;
  entry_t            ent_rdata;

  logic              stg_we;
  logic              dat_we;
  logic [BLK_W-1:0]  dat_waddr;
  logic [7:0]        dat_wdata;
  logic              lnk_we;
  logic [BLK_W-1:0]  lnk_waddr;
  logic [LINK_W-1:0] lnk_wdata;
  logic              ent_we;
  logic [ENT_W-1:0]  ent_waddr, ent_raddr;
  entry_t            ent_wdata;

  logic              stage_hit, key_hit, link_end, too_long, has_next;

  assign stage_hit = cmd_i.ch_valid &&
                     (cmd_i.kind == K_STAGE || cmd_i.kind == K_CREATE ||
                      cmd_i.kind == K_UPDATE);
  assign key_hit   = (ent_rdata.key == key_q);
  assign link_end  = (link_rdata >= LINK_W'(NUM_BLOCKS));
  assign too_long  = stg_ovf_q || (stg_cnt_q > ent_rdata.len);
  assign has_next  = ((idx_q + ECNT_W'(1)) < ent_cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            K_CREATE: state_d = S_CRE_CHK;
            K_UPDATE, K_READ, K_DELETE: state_d = S_LOOK_RD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_CRE_CHK: begin
        if (ent_cnt_q >= ECNT_W'(MAX_ENTRIES) || stg_cnt_q == '0 || stg_ovf_q ||
            free_cnt_q < stg_cnt_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (!taken_q[scan_q] && (pos_q + CNT_W'(1)) == stg_cnt_q) state_d = S_ALLOC_END;
      end
      S_ALLOC_END: state_d = S_TBL_WR;
      S_TBL_WR:    state_d = S_RESP;
      S_LOOK_RD:   state_d = (idx_q >= ent_cnt_q) ? S_RESP : S_LOOK_CMP;
      S_LOOK_CMP: begin
        if (!key_hit) begin
          state_d = S_LOOK_RD;
        end else begin
          case (kind_q)
            K_UPDATE: state_d = too_long ? S_RESP : S_UPD_RD;
            K_READ:   state_d = S_RD_RD;
            K_DELETE: state_d = S_DEL_RD;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: state_d = link_end ? S_RESP : S_UPD_RD;
      S_RD_RD:  state_d = S_RD_WR;
      S_RD_WR: begin
        if (!rq_full_i) state_d = link_end ? S_IDLE : S_RD_RD;
      end
      S_DEL_RD: state_d = S_DEL_WR;
      S_DEL_WR: state_d = link_end ? S_CMP_RD : S_DEL_RD;
      S_CMP_RD: state_d = has_next ? S_CMP_WR : S_RESP;
      S_CMP_WR: state_d = S_CMP_RD;
      S_RESP: begin
        if (!rq_full_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and results.
  always_comb begin
    kind_d     = kind_q;
    key_d      = key_q;
    stg_cnt_d  = stg_cnt_q;
    stg_ovf_d  = stg_ovf_q;
    free_cnt_d = free_cnt_q;
    ent_cnt_d  = ent_cnt_q;
    idx_d      = idx_q;
    b_d        = b_q;
    pos_d      = pos_q;
    prev_d     = prev_q;
    first_d    = first_q;
    scan_d     = scan_q;
    start_d    = start_q;
    len_d      = len_q;
    status_d   = status_q;
    taken_d    = taken_q;
    cmd_take_o = 1'b0;
    stg_we     = 1'b0;
    dat_we     = 1'b0;
    dat_waddr  = b_q[BLK_W-1:0];
    dat_wdata  = stg_rdata;
    lnk_we     = 1'b0;
    lnk_waddr  = prev_q;
    lnk_wdata  = LINK_END;
    ent_we     = 1'b0;
    ent_waddr  = idx_q[ENT_W-1:0];
    ent_wdata  = ent_rdata;
    ent_raddr  = idx_q[ENT_W-1:0];
    rq_push_o  = 1'b0;
    rq_res_o   = '{status: status_q, start: '0, len: '0, idx: '0, ch: '0, last: 1'b1};
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          kind_d     = cmd_i.kind;
          key_d      = cmd_i.key;
          idx_d      = '0;
          pos_d      = '0;
          scan_d     = '0;
          if (stage_hit) begin
            if (stg_cnt_q < CNT_W'(NUM_BLOCKS)) begin
              stg_we    = 1'b1;
              stg_cnt_d = stg_cnt_q + CNT_W'(1);
            end else begin
              stg_ovf_d = 1'b1;
            end
          end
        end
      end
      S_CRE_CHK: begin
        if (ent_cnt_q >= ECNT_W'(MAX_ENTRIES)) status_d = ST_FULL;
        else if (stg_cnt_q == '0)              status_d = ST_EMPTY;
        else if (stg_ovf_q)                    status_d = ST_TOOLONG;
        else if (free_cnt_q < stg_cnt_q)       status_d = ST_NOMEM;
      end
      S_ALLOC: begin
        // Claim the lowest free block and link the previous one to it.
        if (!taken_q[scan_q]) begin
          dat_we          = 1'b1;
          dat_waddr       = scan_q;
          dat_wdata       = stg_rdata;
          taken_d[scan_q] = 1'b1;
          if (pos_q != '0) begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_q;
            lnk_wdata = LINK_W'(scan_q);
          end else begin
            first_d = scan_q;
          end
          prev_d = scan_q;
          pos_d  = pos_q + CNT_W'(1);
        end
        scan_d = scan_q + BLK_W'(1);
      end
      S_ALLOC_END: begin
        lnk_we     = 1'b1;
        lnk_waddr  = prev_q;
        lnk_wdata  = LINK_END;
        free_cnt_d = free_cnt_q - stg_cnt_q;
      end
      S_TBL_WR: begin
        ent_we    = 1'b1;
        ent_waddr = ent_cnt_q[ENT_W-1:0];
        ent_wdata = '{key: key_q, start: first_q, len: stg_cnt_q};
        ent_cnt_d = ent_cnt_q + ECNT_W'(1);
        status_d  = ST_OK;
      end
      S_LOOK_RD: begin
        if (idx_q >= ent_cnt_q) status_d = ST_NOTFOUND;
      end
      S_LOOK_CMP: begin
        if (!key_hit) begin
          idx_d = idx_q + ECNT_W'(1);
        end else begin
          start_d  = ent_rdata.start;
          len_d    = ent_rdata.len;
          b_d      = LINK_W'(ent_rdata.start);
          pos_d    = '0;
          status_d = (kind_q == K_UPDATE && too_long) ? ST_TOOLONG : ST_OK;
        end
      end
      S_UPD_WR: begin
        // Rewrite one block: staged character or zero padding.
        dat_we    = 1'b1;
        dat_waddr = b_q[BLK_W-1:0];
        dat_wdata = (pos_q < stg_cnt_q) ? stg_rdata : 8'd0;
        pos_d     = pos_q + CNT_W'(1);
        b_d       = link_rdata;
      end
      S_RD_WR: begin
        if (!rq_full_i) begin
          rq_push_o = 1'b1;
          b_d       = link_rdata;
        end
        rq_res_o = '{status: ST_OK, start: 6'(start_q), len: 7'(len_q),
                     idx: 6'(b_q[BLK_W-1:0]), ch: data_rdata, last: link_end};
      end
      S_DEL_WR: begin
        taken_d[b_q[BLK_W-1:0]] = 1'b0;
        free_cnt_d = free_cnt_q + CNT_W'(1);
        b_d        = link_rdata;
      end
      S_CMP_RD: begin
        ent_raddr = ENT_W'(idx_q + ECNT_W'(1));
        if (!has_next) begin
          ent_cnt_d = ent_cnt_q - ECNT_W'(1);
          status_d  = ST_OK;
        end
      end
      S_CMP_WR: begin
        // Close the gap in the table one entry at a time.
        ent_we    = 1'b1;
        ent_waddr = idx_q[ENT_W-1:0];
        ent_wdata = ent_rdata;
        idx_d     = idx_q + ECNT_W'(1);
      end
      S_RESP: begin
        if (!rq_full_i) begin
          rq_push_o = 1'b1;
          if (kind_q == K_CREATE || kind_q == K_UPDATE) begin
            stg_cnt_d = '0;
            stg_ovf_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      stg_cnt_q  <= '0;
      stg_ovf_q  <= 1'b0;
      free_cnt_q <= CNT_W'(NUM_BLOCKS);
      ent_cnt_q  <= '0;
      taken_q    <= '0;
      kind_q     <= K_STAGE;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      stg_cnt_q  <= stg_cnt_d;
      stg_ovf_q  <= stg_ovf_d;
      free_cnt_q <= free_cnt_d;
      ent_cnt_q  <= ent_cnt_d;
      taken_q    <= taken_d;
      kind_q     <= kind_d;
      status_q   <= status_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    b_q     <= b_d;
    pos_q   <= pos_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    scan_q  <= scan_d;
    start_q <= start_d;
    len_q   <= len_d;
  end

  // Memory ports, all reads registered.
  always_ff @(posedge clk_i) begin
    if (stg_we) stg_mem[stg_cnt_q[BLK_W-1:0]] <= cmd_i.ch;
    stg_rdata <= stg_mem[pos_d[BLK_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) data_mem[dat_waddr] <= dat_wdata;
    data_rdata <= data_mem[b_q[BLK_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) link_mem[lnk_waddr] <= lnk_wdata;
    link_rdata <= link_mem[b_q[BLK_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rdata <= ent_mem[ent_raddr];
  end

`ifndef SYNTH
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CNT_W'(NUM_BLOCKS))
    else $error("free block count out of range");
  a_ent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_cnt_q <= ECNT_W'(MAX_ENTRIES))
    else $error("table count out of range");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push_o |-> !rq_full_i)
    else $error("result pushed into a full queue");
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (free_cnt_q >= stg_cnt_q))
    else $error("allocation started without enough free blocks");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> (state_q == S_IDLE && cmd_valid_i))
    else $error("command taken while busy");
`endif

endmodule
`default_nettype wire

### hdl/linked_block_file_store_top.sv
// Top level of the linked-block file store: front end, command engine and
// result queue. Depends on lbfs_pkg, lbfs_front, lbfs_back and lbfs_rq.
//
//   channel  | handshake          | beat
//   ---------+--------------------+---------------------------------------
//   input    | push_i / full_o    | operation, file_key, data_char, flags
//   result   | pop_i / empty_o    | status, block fields, last_result
//
// A character beat that does not end a command is staged in idle.
// Create checks its limits, scans blocks up to its last free block, ends
// the chain, writes the table entry and sends a status beat. Update, read
// and delete search the table and walk the chain; update and delete add a
// status beat, and delete moves later table entries down to close the gap.
// Reset needs no clearing pass: block state uses taken bits in flip-flops.
// Either side may stall; a two-beat input queue and a four-beat result
// queue decouple them.
`default_nettype none
module linked_block_file_store_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] file_key_i,
  input  wire logic [7:0]  data_char_i,
  input  wire logic        char_valid_i,
  input  wire logic        last_char_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [2:0]       status_o,
  output logic [5:0]       start_block_o,
  output logic [6:0]       file_length_o,
  output logic [5:0]       block_index_o,
  output logic [7:0]       block_char_o,
  output logic             last_result_o
);
  import lbfs_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  res_t eng_res, out_res;
  logic rq_push, rq_full;

  lbfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .operation_i  (operation_i),
    .file_key_i   (file_key_i),
    .data_char_i  (data_char_i),
    .char_valid_i (char_valid_i),
    .last_char_i  (last_char_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_take_i   (cmd_take),
    .cmd_o        (cmd)
  );

  lbfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .rq_full_i   (rq_full),
    .rq_push_o   (rq_push),
    .rq_res_o    (eng_res)
  );

  lbfs_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .res_i   (eng_res),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .res_o   (out_res)
  );

  assign status_o      = out_res.status;
  assign start_block_o = out_res.start;
  assign file_length_o = out_res.len;
  assign block_index_o = out_res.idx;
  assign block_char_o  = out_res.ch;
  assign last_result_o = out_res.last;

endmodule
`default_nettype wire
